FILE: sv/eepts_pkg.sv
// ----------------------------------------------------------------------------
// eepts_pkg
// Shared types, constants and helpers for the EEPROM page transfer splitter.
// ----------------------------------------------------------------------------
package eepts_pkg;

    // Sizing
    localparam int P_MAX_REQUEST_LEN = 256;
    localparam int P_ADDRESS_BITS    = 18;
    localparam logic [17:0] P_ADDR_MASK = 18'((64'd1 << P_ADDRESS_BITS) - 64'd1);
    localparam logic [3:0]  P_NUM_CODES      = 4'd12;
    localparam logic [3:0]  P_WIDE_FROM_CODE = 4'd5;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OVER_CAP    = 2'd1;
    localparam logic [1:0] ST_BAD_CAP     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [1:0] CFG_BASE_DEV   = 2'd1;
    localparam logic [1:0] CFG_OVF_EN     = 2'd2;

    // Request request type codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [17:0] start_address;
        logic [8:0]  byte_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  device_address;
        logic [15:0] word_address;
        logic        wide_word_address;
        logic [8:0]  transfer_length;
        logic        last_transfer;
    } t_rsp;

    // Live configuration
    typedef struct packed {
        logic [3:0] capacity_code;
        logic [6:0] base_device_address;
        logic       overflow_check_enable;
    } t_cfg;

    // Classified job handed from the front end to the back end
    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] addr;
        logic [8:0]  count;
        logic        split;
    } t_job;

    // Page size in bytes for each supported capacity code
    function automatic logic [8:0] page_bytes(input logic [3:0] code);
        logic [8:0] pb;
        case (code)
            4'd0, 4'd1:       pb = 9'd8;
            4'd2, 4'd3, 4'd4: pb = 9'd16;
            4'd5, 4'd6:       pb = 9'd32;
            4'd7, 4'd8:       pb = 9'd64;
            4'd9:             pb = 9'd128;
            default:          pb = 9'd256;
        endcase
        return pb;
    endfunction

endpackage

FILE: sv/eeprom_page_transfer_splitter_core.sv
// ----------------------------------------------------------------------------
// eeprom_page_transfer_splitter_core
// Plans serial EEPROM bus transfers for read and page-split write requests.
// ----------------------------------------------------------------------------
// A request moves through the job queue, job registers and output register.
// Beats: one beat per cycle while the sink does not stall; a request gives
//   1 to 33 transfers, planned by the back-end job walk.
// A two-entry job queue lets requests be accepted while the back end works.
// Reset: synchronous, active low; clears control state and the config
//   registers to capacity code 0, base address 80, overflow check on.
module eeprom_page_transfer_splitter_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  eepts_pkg::t_req  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output eepts_pkg::t_rsp  o_out_data
);

    eepts_pkg::t_cfg r_cfg;
    logic            q_full;
    logic            q_valid;
    logic            push;
    logic            pop;
    eepts_pkg::t_job front_job;
    eepts_pkg::t_job q_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity_code         <= 4'd0;
            r_cfg.base_device_address   <= 7'd80;
            r_cfg.overflow_check_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                eepts_pkg::CFG_CAPACITY: r_cfg.capacity_code <= i_cfg_wdata[3:0];
                eepts_pkg::CFG_BASE_DEV: r_cfg.base_device_address <= i_cfg_wdata;
                eepts_pkg::CFG_OVF_EN:   r_cfg.overflow_check_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = q_full;

    eepts_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    eepts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    eepts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sv/eepts_front.sv
// ----------------------------------------------------------------------------
// eepts_front
// Accepts requests, runs the error checks and classifies each request into a
// job for the back end: an error, a single transfer or a page-split write.
// ----------------------------------------------------------------------------
module eepts_front (
    input  logic             i_in_valid,
    input  eepts_pkg::t_req  i_in_data,
    input  eepts_pkg::t_cfg  i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output eepts_pkg::t_job  o_job
);

    logic [17:0] start;
    logic [18:0] end_addr;
    logic [18:0] capacity;

    assign start    = i_in_data.start_address & eepts_pkg::P_ADDR_MASK;
    assign end_addr = {1'b0, start} + {10'd0, i_in_data.byte_count};
    assign capacity = 19'd128 << i_cfg.capacity_code;

    // Error precedence: capacity code, length, then overflow
    always_comb begin
        o_job.addr  = start;
        o_job.count = i_in_data.byte_count;
        o_job.split = 1'b0;
        if (i_cfg.capacity_code >= eepts_pkg::P_NUM_CODES) begin
            o_job.status = eepts_pkg::ST_BAD_CAP;
        end else if ({1'b0, i_in_data.byte_count} >
                     10'(eepts_pkg::P_MAX_REQUEST_LEN)) begin
            o_job.status = eepts_pkg::ST_TOO_LONG;
        end else if (i_cfg.overflow_check_enable && (end_addr > capacity)) begin
            o_job.status = eepts_pkg::ST_OVER_CAP;
        end else begin
            o_job.status = eepts_pkg::ST_OK;
            o_job.split  = (i_in_data.req_type == eepts_pkg::REQ_WRITE) &&
                           (i_in_data.byte_count != 9'd0);
        end
    end

    assign o_push = i_in_valid && !i_q_full;

endmodule

FILE: sv/eepts_queue.sv
// ----------------------------------------------------------------------------
// eepts_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module eepts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  eepts_pkg::t_job  i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output eepts_pkg::t_job  o_job
);

    eepts_pkg::t_job r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: sv/eepts_back.sv
// ----------------------------------------------------------------------------
// eepts_back
// Walks one job at a time, one planned transfer per cycle unless stalled,
// into an output register that holds a finished beat while the sink stalls.
// ----------------------------------------------------------------------------
module eepts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  eepts_pkg::t_cfg  i_cfg,
    input  logic             i_q_valid,
    input  eepts_pkg::t_job  i_q_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output eepts_pkg::t_rsp  o_out_data
);

    logic            r_busy;
    logic [1:0]      r_status;
    logic [17:0]     r_addr;
    logic [8:0]      r_left;
    logic            r_split;
    logic            r_out_valid;
    eepts_pkg::t_rsp r_out;

    logic            emit;
    logic            last;
    logic            wide;
    logic [8:0]      page;
    logic [8:0]      room;
    logic [8:0]      xfer;
    eepts_pkg::t_rsp rsp;

    // Transfer size: bytes up to the page end, capped by what is left
    assign page = eepts_pkg::page_bytes(i_cfg.capacity_code);
    assign room = page - {1'b0, r_addr[7:0] & (page[7:0] - 8'd1)};
    assign xfer = (room > r_left) ? r_left : room;
    assign last = !r_split || (xfer == r_left);
    assign wide = (i_cfg.capacity_code >= eepts_pkg::P_WIDE_FROM_CODE);

    assign emit  = r_busy && (!r_out_valid || !i_out_stall);
    assign o_pop = i_q_valid && (!r_busy || (emit && last));

    // Result beat
    always_comb begin
        rsp.status          = r_status;
        rsp.last_transfer   = last;
        if (r_status != eepts_pkg::ST_OK) begin
            rsp.device_address    = 7'd0;
            rsp.word_address      = 16'd0;
            rsp.wide_word_address = 1'b0;
            rsp.transfer_length   = 9'd0;
        end else begin
            rsp.wide_word_address = wide;
            rsp.transfer_length   = r_split ? xfer : r_left;
            if (wide) begin
                rsp.device_address = i_cfg.base_device_address |
                                     {5'd0, r_addr[17:16]};
                rsp.word_address   = r_addr[15:0];
            end else begin
                rsp.device_address = i_cfg.base_device_address |
                                     {4'd0, r_addr[10:8]};
                rsp.word_address   = {8'd0, r_addr[7:0]};
            end
        end
    end

    // Job walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_q_job.status;
            r_addr   <= i_q_job.addr;
            r_left   <= i_q_job.count;
            r_split  <= i_q_job.split;
        end else if (emit) begin
            r_addr <= (r_addr + {9'd0, xfer}) & eepts_pkg::P_ADDR_MASK;
            r_left <= r_left - xfer;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
